// File: hdl/rpjs_pkg.sv
// Shared types, codes and lookup tables for the raster pixel to JPEG sample block.
// No dependencies; every other file in hdl uses this package.
package rpjs_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PIXEL_KIND    = 2'd0,
    CFG_SAMPLE_DEPTH  = 2'd1,
    CFG_MASK_ENABLED  = 2'd2,
    CFG_PALETTE_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_MONO    = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_GRAY    = 2'd2,
    KIND_RGB     = 2'd3
  } pixel_kind_t;

  typedef enum logic [1:0] {
    DEPTH_1BIT = 2'd0,
    DEPTH_2BIT = 2'd1,
    DEPTH_4BIT = 2'd2,
    DEPTH_8BIT = 2'd3
  } sample_depth_t;

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_LOAD    = 1'b1
  } operation_t;

  localparam logic [1:0] COMP_ONE   = 2'd1;
  localparam logic [1:0] COMP_THREE = 2'd3;
  localparam logic [7:0] WHITE      = 8'd255;
  localparam logic [7:0] BLACK      = 8'd0;

  typedef struct packed {
    logic       operation;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
    logic [7:0] sample_c;
    logic [7:0] mask_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] entry_alpha;
  } in_item_t;

  typedef struct packed {
    logic [1:0] component_count;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
  } out_item_t;

  function automatic logic [7:0] gray2_expand(input logic [1:0] s);
    logic [7:0] v;
    unique case (s)
      2'd0:    v = 8'd0;
      2'd1:    v = 8'd86;
      2'd2:    v = 8'd170;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] gray4_expand(input logic [3:0] s);
    logic [7:0] v;
    unique case (s)
      4'd0:    v = 8'd0;
      4'd1:    v = 8'd17;
      4'd2:    v = 8'd34;
      4'd3:    v = 8'd51;
      4'd4:    v = 8'd68;
      4'd5:    v = 8'd85;
      4'd6:    v = 8'd102;
      4'd7:    v = 8'd119;
      4'd8:    v = 8'd137;
      4'd9:    v = 8'd154;
      4'd10:   v = 8'd171;
      4'd11:   v = 8'd188;
      4'd12:   v = 8'd205;
      4'd13:   v = 8'd222;
      4'd14:   v = 8'd239;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/raster_pixel_to_jpeg_sample.sv
// Top level of the raster pixel to JPEG sample converter with its palette memory.
// Depends on rpjs_pkg for the beat structs, register codes and gray tables.
// A convert beat is registered in stage one with its palette read, then in the output register.
// Throughput: one beat per cycle in and out while out_ready is high; load beats write the palette and give no output.
// Reset (synchronous, rst_n low) clears the pipeline valids and sets the registers to defaults;
// palette contents are undefined until loaded.
module raster_pixel_to_jpeg_sample #(
  parameter int PALETTE_DEPTH = rpjs_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rpjs_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rpjs_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [rpjs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rpjs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  logic [1:0] pixel_kind_r;
  logic [1:0] sample_depth_r;
  logic       mask_enabled_r;
  logic [8:0] palette_count_r;

  logic [31:0] palette_mem [PALETTE_DEPTH];
  logic [31:0] rd_data_r;

  logic       s1_v_r;
  logic [7:0] sa_r, sb_r, sc_r;
  logic       masked_r;

  logic                o_v_r;
  rpjs_pkg::out_item_t o_data_r;
  rpjs_pkg::out_item_t o_data_nxt;

  logic       s1_go;
  logic       in_fire;
  logic       is_load;
  logic [8:0] limit;
  logic       in_range;
  logic [7:0] gray;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_kind_r    <= rpjs_pkg::KIND_GRAY;
      sample_depth_r  <= rpjs_pkg::DEPTH_8BIT;
      mask_enabled_r  <= 1'b0;
      palette_count_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (rpjs_pkg::cfg_reg_t'(cfg_index))
        rpjs_pkg::CFG_PIXEL_KIND:    pixel_kind_r    <= cfg_wdata[1:0];
        rpjs_pkg::CFG_SAMPLE_DEPTH:  sample_depth_r  <= cfg_wdata[1:0];
        rpjs_pkg::CFG_MASK_ENABLED:  mask_enabled_r  <= cfg_wdata[0];
        rpjs_pkg::CFG_PALETTE_COUNT: palette_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_go    = !o_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_go;
  assign in_fire  = in_valid && in_ready;
  assign is_load  = (in_data.operation == rpjs_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (in_fire && is_load && ({1'b0, in_data.entry_index} < DEPTH9)) begin
      palette_mem[in_data.entry_index[AW-1:0]] <= {in_data.entry_red, in_data.entry_green,
                                                   in_data.entry_blue, in_data.entry_alpha};
    end
    if (in_fire && !is_load) begin
      rd_data_r <= palette_mem[in_data.sample_a[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !is_load) begin
      sa_r     <= in_data.sample_a;
      sb_r     <= in_data.sample_b;
      sc_r     <= in_data.sample_c;
      masked_r <= mask_enabled_r && (in_data.mask_byte == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid && !is_load;
    end
  end

  assign limit    = (palette_count_r > DEPTH9) ? DEPTH9 : palette_count_r;
  assign in_range = ({1'b0, sa_r} < limit);

  always_comb begin
    unique case (rpjs_pkg::sample_depth_t'(sample_depth_r))
      rpjs_pkg::DEPTH_2BIT: gray = (sa_r < 8'd4)  ? rpjs_pkg::gray2_expand(sa_r[1:0])
                                                   : rpjs_pkg::BLACK;
      rpjs_pkg::DEPTH_4BIT: gray = (sa_r < 8'd16) ? rpjs_pkg::gray4_expand(sa_r[3:0])
                                                   : rpjs_pkg::BLACK;
      default:              gray = sa_r;
    endcase
  end

  always_comb begin
    o_data_nxt = '{component_count: rpjs_pkg::COMP_ONE, out_first: rpjs_pkg::BLACK,
                   out_second: rpjs_pkg::BLACK, out_third: rpjs_pkg::BLACK};
    unique case (rpjs_pkg::pixel_kind_t'(pixel_kind_r))
      rpjs_pkg::KIND_MONO: begin
        if (masked_r || sa_r == 8'd0) begin
          o_data_nxt.out_first = rpjs_pkg::WHITE;
        end
      end
      rpjs_pkg::KIND_PALETTE: begin
        o_data_nxt.component_count = rpjs_pkg::COMP_THREE;
        if (masked_r || (in_range && rd_data_r[7:0] == 8'd0)) begin
          o_data_nxt.out_first  = rpjs_pkg::WHITE;
          o_data_nxt.out_second = rpjs_pkg::WHITE;
          o_data_nxt.out_third  = rpjs_pkg::WHITE;
        end else if (in_range) begin
          o_data_nxt.out_first  = rd_data_r[31:24];
          o_data_nxt.out_second = rd_data_r[23:16];
          o_data_nxt.out_third  = rd_data_r[15:8];
        end
      end
      rpjs_pkg::KIND_GRAY: begin
        o_data_nxt.out_first = masked_r ? rpjs_pkg::WHITE : gray;
      end
      rpjs_pkg::KIND_RGB: begin
        o_data_nxt.component_count = rpjs_pkg::COMP_THREE;
        o_data_nxt.out_first  = masked_r ? rpjs_pkg::WHITE : sa_r;
        o_data_nxt.out_second = masked_r ? rpjs_pkg::WHITE : sb_r;
        o_data_nxt.out_third  = masked_r ? rpjs_pkg::WHITE : sc_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (s1_go) begin
      o_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_v_r) begin
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_data_r;

endmodule

// File: hdl/rpjs_checker.sv
// Port-level checker for the raster pixel to JPEG sample converter, bound to the top level.
// Depends on rpjs_pkg for the beat struct types and component count codes.
module rpjs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input rpjs_pkg::in_item_t               in_data,
  input logic                             out_valid,
  input logic                             out_ready,
  input rpjs_pkg::out_item_t              out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("Waiting input beat changed or dropped.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled output beat changed or dropped.");

  a_count_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.component_count == rpjs_pkg::COMP_ONE ||
                   out_data.component_count == rpjs_pkg::COMP_THREE))
    else $error("Output beat carries an invalid component count.");

  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.component_count == rpjs_pkg::COMP_ONE |->
      out_data.out_second == 8'd0 && out_data.out_third == 8'd0)
    else $error("Single component beat has nonzero second or third component.");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("Output valid high right after reset.");

endmodule

bind raster_pixel_to_jpeg_sample rpjs_checker u_rpjs_checker (.*);

// File: dv/tb_raster_pixel_to_jpeg_sample.sv
// Self-checking testbench for raster_pixel_to_jpeg_sample: directed cases, then random phases.
// Depends on rpjs_pkg and the block itself; expected samples come from a predictor kept here.
module tb_raster_pixel_to_jpeg_sample;

  localparam int DEPTH       = rpjs_pkg::PALETTE_DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASES      = 7;
  localparam int PHASE_PIXELS = 90;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  rpjs_pkg::in_item_t               in_data;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  rpjs_pkg::out_item_t              out_data;
  logic                             cfg_wr_en;
  logic [rpjs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rpjs_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  rpjs_pkg::pixel_kind_t   kind_q  = rpjs_pkg::KIND_GRAY;
  rpjs_pkg::sample_depth_t depth_q = rpjs_pkg::DEPTH_8BIT;
  logic                    mask_q  = 1'b0;
  logic [8:0]              count_q = 9'd0;

  logic [31:0] palette_mirror [DEPTH];
  bit          entry_loaded [DEPTH];
  logic [7:0]  gray2_lut [4]  = '{8'd0, 8'd86, 8'd170, 8'd255};
  logic [7:0]  gray4_lut [16] = '{8'd0, 8'd17, 8'd34, 8'd51, 8'd68, 8'd85, 8'd102, 8'd119,
                                  8'd137, 8'd154, 8'd171, 8'd188, 8'd205, 8'd222, 8'd239,
                                  8'd255};

  rpjs_pkg::out_item_t expected_samples [$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  bit        gaps_on     = 1'b1;
  bit        stalls_on   = 1'b1;
  bit        hold_req    = 1'b0;

  raster_pixel_to_jpeg_sample uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int palette_limit();
    return (int'(count_q) > DEPTH) ? DEPTH : int'(count_q);
  endfunction

  function automatic void predict_components(rpjs_pkg::in_item_t it);
    rpjs_pkg::out_item_t e;
    logic                masked;
    logic [31:0]         entry;
    if (it.operation == rpjs_pkg::OP_LOAD) begin
      palette_mirror[it.entry_index] = {it.entry_red, it.entry_green, it.entry_blue,
                                        it.entry_alpha};
      entry_loaded[it.entry_index] = 1'b1;
      return;
    end
    e = '0;
    masked = mask_q && (it.mask_byte == 8'd0);
    case (kind_q)
      rpjs_pkg::KIND_MONO: begin
        e.component_count = rpjs_pkg::COMP_ONE;
        e.out_first = (masked || it.sample_a == 8'd0) ? rpjs_pkg::WHITE : rpjs_pkg::BLACK;
      end
      rpjs_pkg::KIND_PALETTE: begin
        e.component_count = rpjs_pkg::COMP_THREE;
        if (masked) begin
          {e.out_first, e.out_second, e.out_third} = {3{rpjs_pkg::WHITE}};
        end else if (int'(it.sample_a) < palette_limit()) begin
          entry = palette_mirror[it.sample_a];
          if (entry[7:0] == 8'd0) begin
            {e.out_first, e.out_second, e.out_third} = {3{rpjs_pkg::WHITE}};
          end else begin
            {e.out_first, e.out_second, e.out_third} = entry[31:8];
          end
        end
      end
      rpjs_pkg::KIND_GRAY: begin
        e.component_count = rpjs_pkg::COMP_ONE;
        if (masked) begin
          e.out_first = rpjs_pkg::WHITE;
        end else begin
          case (depth_q)
            rpjs_pkg::DEPTH_2BIT: e.out_first = (it.sample_a < 8'd4) ?
                                      gray2_lut[it.sample_a[1:0]] : rpjs_pkg::BLACK;
            rpjs_pkg::DEPTH_4BIT: e.out_first = (it.sample_a < 8'd16) ?
                                      gray4_lut[it.sample_a[3:0]] : rpjs_pkg::BLACK;
            default:              e.out_first = it.sample_a;
          endcase
        end
      end
      default: begin
        e.component_count = rpjs_pkg::COMP_THREE;
        if (masked) begin
          {e.out_first, e.out_second, e.out_third} = {3{rpjs_pkg::WHITE}};
        end else begin
          {e.out_first, e.out_second, e.out_third} = {it.sample_a, it.sample_b, it.sample_c};
        end
      end
    endcase
    expected_samples.push_back(e);
  endfunction

  function automatic rpjs_pkg::in_item_t make_pixel();
    rpjs_pkg::in_item_t it;
    logic [95:0]        raw;
    int                 lim;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(rpjs_pkg::in_item_t)-1:0];
    lim = palette_limit();
    it.operation = ($urandom_range(0, 7) == 0) ? rpjs_pkg::OP_LOAD : rpjs_pkg::OP_CONVERT;
    if (it.operation == rpjs_pkg::OP_CONVERT) begin
      if ($urandom_range(0, 4) == 0) it.mask_byte = 8'd0;
      case (kind_q)
        rpjs_pkg::KIND_MONO: if ($urandom_range(0, 2) == 0) it.sample_a = 8'd0;
        rpjs_pkg::KIND_PALETTE: if (lim > 0 && $urandom_range(0, 4) != 0)
          it.sample_a = 8'($urandom_range(0, lim - 1));
        rpjs_pkg::KIND_GRAY: begin
          if ($urandom_range(0, 3) != 0) begin
            case (depth_q)
              rpjs_pkg::DEPTH_1BIT: it.sample_a = 8'($urandom_range(0, 1));
              rpjs_pkg::DEPTH_2BIT: it.sample_a = 8'($urandom_range(0, 3));
              rpjs_pkg::DEPTH_4BIT: it.sample_a = 8'($urandom_range(0, 15));
              default:              it.sample_a = 8'($urandom_range(0, 255));
            endcase
          end
        end
        default: it.sample_a = it.sample_a;
      endcase
      // A palette read of an entry that was never loaded becomes a load of that entry.
      if (kind_q == rpjs_pkg::KIND_PALETTE && int'(it.sample_a) < lim &&
          !entry_loaded[it.sample_a]) begin
        it.operation = rpjs_pkg::OP_LOAD;
        it.entry_index = it.sample_a;
      end
    end
    if (it.operation == rpjs_pkg::OP_LOAD && $urandom_range(0, 3) == 0) it.entry_alpha = 8'd0;
    return it;
  endfunction

  function automatic rpjs_pkg::in_item_t make_convert(logic [7:0] sa, logic [7:0] sb,
                                                      logic [7:0] sc, logic [7:0] mb);
    rpjs_pkg::in_item_t it;
    it = '0;
    it.operation = rpjs_pkg::OP_CONVERT;
    it.sample_a = sa;
    it.sample_b = sb;
    it.sample_c = sc;
    it.mask_byte = mb;
    return it;
  endfunction

  function automatic rpjs_pkg::in_item_t make_load(logic [7:0] idx, logic [7:0] r,
                                                   logic [7:0] g, logic [7:0] b,
                                                   logic [7:0] a);
    rpjs_pkg::in_item_t it;
    it = '0;
    it.operation = rpjs_pkg::OP_LOAD;
    it.entry_index = idx;
    it.entry_red = r;
    it.entry_green = g;
    it.entry_blue = b;
    it.entry_alpha = a;
    return it;
  endfunction

  // Starts and ends at a falling edge; valid stays high for a following beat.
  task automatic send_beat(rpjs_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_components(it);
    @(negedge clk);
  endtask

  task automatic send_item(rpjs_pkg::in_item_t it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    send_beat(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(rpjs_pkg::cfg_reg_t idx, logic [rpjs_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rpjs_pkg::CFG_PIXEL_KIND:   kind_q = rpjs_pkg::pixel_kind_t'(val[1:0]);
      rpjs_pkg::CFG_SAMPLE_DEPTH: depth_q = rpjs_pkg::sample_depth_t'(val[1:0]);
      rpjs_pkg::CFG_MASK_ENABLED: mask_q = val[0];
      default:                    count_q = val;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(rpjs_pkg::pixel_kind_t kind, rpjs_pkg::sample_depth_t depth,
                           logic mask, logic [8:0] count);
    drain();
    write_reg(rpjs_pkg::CFG_PIXEL_KIND, 9'(kind));
    write_reg(rpjs_pkg::CFG_SAMPLE_DEPTH, 9'(depth));
    write_reg(rpjs_pkg::CFG_MASK_ENABLED, 9'(mask));
    write_reg(rpjs_pkg::CFG_PALETTE_COUNT, count);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(make_convert(8'd0, 8'd0, 8'd0, 8'd1));
    send_item(make_convert(8'd255, 8'd255, 8'd255, 8'd255));
    send_item(make_convert(8'd90, 8'd0, 8'd0, 8'd0));
  endtask

  task automatic test_gray_depths();
    configure(rpjs_pkg::KIND_GRAY, rpjs_pkg::DEPTH_1BIT, 1'b0, 9'd0);
    send_item(make_convert(8'd1, 8'd0, 8'd0, 8'd5));
    send_item(make_convert(8'd255, 8'd0, 8'd0, 8'd5));
    configure(rpjs_pkg::KIND_GRAY, rpjs_pkg::DEPTH_2BIT, 1'b0, 9'd0);
    send_item(make_convert(8'd2, 8'd0, 8'd0, 8'd5));
    send_item(make_convert(8'd4, 8'd0, 8'd0, 8'd5));
    configure(rpjs_pkg::KIND_GRAY, rpjs_pkg::DEPTH_4BIT, 1'b1, 9'd0);
    send_item(make_convert(8'd14, 8'd0, 8'd0, 8'd5));
    send_item(make_convert(8'd16, 8'd0, 8'd0, 8'd5));
    send_item(make_convert(8'd7, 8'd0, 8'd0, 8'd0));
  endtask

  task automatic test_mono();
    configure(rpjs_pkg::KIND_MONO, rpjs_pkg::DEPTH_8BIT, 1'b0, 9'd0);
    send_item(make_convert(8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_convert(8'd128, 8'd0, 8'd0, 8'd0));
  endtask

  task automatic test_rgb();
    configure(rpjs_pkg::KIND_RGB, rpjs_pkg::DEPTH_8BIT, 1'b1, 9'd0);
    send_item(make_convert(8'd255, 8'd0, 8'd128, 8'd1));
    send_item(make_convert(8'd10, 8'd20, 8'd30, 8'd0));
  endtask

  task automatic test_palette();
    configure(rpjs_pkg::KIND_PALETTE, rpjs_pkg::DEPTH_8BIT, 1'b0, 9'd2);
    send_item(make_load(8'd0, 8'd12, 8'd34, 8'd56, 8'd0));
    send_item(make_load(8'd1, 8'd255, 8'd0, 8'd170, 8'd255));
    send_item(make_load(8'd255, 8'd1, 8'd2, 8'd3, 8'd1));
    send_item(make_convert(8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_convert(8'd1, 8'd0, 8'd0, 8'd0));
    send_item(make_convert(8'd2, 8'd0, 8'd0, 8'd0));
    configure(rpjs_pkg::KIND_PALETTE, rpjs_pkg::DEPTH_8BIT, 1'b0, 9'd256);
    send_item(make_convert(8'd255, 8'd0, 8'd0, 8'd0));
    configure(rpjs_pkg::KIND_PALETTE, rpjs_pkg::DEPTH_8BIT, 1'b1, 9'd511);
    send_item(make_convert(8'd255, 8'd0, 8'd0, 8'd9));
    send_item(make_convert(8'd1, 8'd0, 8'd0, 8'd0));
    configure(rpjs_pkg::KIND_PALETTE, rpjs_pkg::DEPTH_8BIT, 1'b0, 9'd0);
    send_item(make_convert(8'd0, 8'd0, 8'd0, 8'd0));
  endtask

  task automatic test_backpressure();
    configure(rpjs_pkg::KIND_RGB, rpjs_pkg::DEPTH_8BIT, 1'b0, 9'd0);
    hold_req = 1'b1;
    repeat (40) send_beat(make_pixel());
    drain();
  endtask

  task automatic test_random_phases();
    int                    converts;
    logic [8:0]            count;
    rpjs_pkg::pixel_kind_t kind;
    rpjs_pkg::in_item_t    it;
    for (int p = 0; p < PHASES; p++) begin
      gaps_on = (p != PHASES - 1);
      stalls_on = (p != PHASES - 1);
      kind = (p < 4) ? rpjs_pkg::pixel_kind_t'(p) : rpjs_pkg::pixel_kind_t'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       count = 9'd0;
        1:       count = 9'd1;
        2:       count = 9'd2;
        3:       count = 9'd255;
        4:       count = 9'd256;
        5:       count = 9'd257;
        6:       count = 9'd511;
        default: count = 9'($urandom_range(0, 511));
      endcase
      configure(kind, rpjs_pkg::sample_depth_t'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), count);
      converts = 0;
      while (converts < PHASE_PIXELS) begin
        it = make_pixel();
        send_item(it);
        if (it.operation == rpjs_pkg::OP_CONVERT) converts++;
      end
    end
  endtask

  initial begin : receiver
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    rpjs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample: expected none, actual %0d %0d %0d %0d",
                 $time, out_data.component_count, out_data.out_first, out_data.out_second,
                 out_data.out_third);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (out_data.component_count !== want.component_count ||
            out_data.out_first !== want.out_first ||
            out_data.out_second !== want.out_second ||
            out_data.out_third !== want.out_third) begin
          $display("%0t: mismatch: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                   $time, want.component_count, want.out_first, want.out_second,
                   want.out_third, out_data.component_count, out_data.out_first,
                   out_data.out_second, out_data.out_third);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_gray_depths();
    test_mono();
    test_rgb();
    test_palette();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
